@@ design/npm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npm_pkg
// Shared types and constants of the nearest point matcher: store size,
// field widths, operation codes, store entry layout and sequencer states.
// ----------------------------------------------------------------------------
package npm_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int RESULT_CAP  = 64;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int RES_W       = $clog2(RESULT_CAP + 1);
  localparam int COORD_W     = 16;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = 33;
  localparam int REF_IDX_W   = 6;
  localparam int ENTRY_W     = 2 * COORD_W + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [RES_W-1:0]          res_cnt_t;
  typedef logic [REF_IDX_W-1:0]      ref_idx_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_DRAIN = 2'd3
  } op_t;

  typedef enum logic {
    KIND_QUERY = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_t;

  typedef struct packed {
    logic   mark;
    coord_t x;
    coord_t y;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QSCAN,
    ST_QOUT,
    ST_MARK,
    ST_DRAIN
  } state_t;

endpackage

@@ design/npm_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npm_in_if
// Input channel of the nearest point matcher: operation and point word.
// ----------------------------------------------------------------------------
interface npm_in_if;

  logic            valid;
  logic            ready;
  npm_pkg::op_t    operation;
  npm_pkg::coord_t point_x;
  npm_pkg::coord_t point_y;

  modport source (output valid, output operation, output point_x, output point_y,
                  input ready);
  modport sink   (input valid, input operation, input point_x, input point_y,
                  output ready);

endinterface

@@ design/npm_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npm_out_if
// Result channel of the nearest point matcher: query answers and drained
// reference points.
// ----------------------------------------------------------------------------
interface npm_out_if;

  logic              valid;
  logic              ready;
  npm_pkg::kind_t    kind;
  logic              matched;
  npm_pkg::ref_idx_t ref_index;
  npm_pkg::coord_t   ref_px;
  npm_pkg::coord_t   ref_py;
  npm_pkg::dist_t    dist_sq;
  logic              last;

  modport source (output valid, output kind, output matched, output ref_index,
                  output ref_px, output ref_py, output dist_sq, output last,
                  input ready);
  modport sink   (input valid, input kind, input matched, input ref_index,
                  input ref_px, input ref_py, input dist_sq, input last,
                  output ready);

endinterface

@@ design/npm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module npm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/nearest_point_match_threshold_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_match_threshold_unit
// Reference point store with nearest point query, threshold match marking
// and drain of unmatched points. Points and marks live in one RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | word
//  in_ch    | in  | valid/ready        | operation, point_x, point_y
//  out_ch   | out | valid/ready        | kind, matched, ref_index, ref_px,
//           |     |                    | ref_py, dist_sq, last
//  cfg      | in  | cfg_we, no ready   | cfg_wdata = threshold_sq
//
//  clear and load complete in the idle state; a query scans the store
//  through the RAM read port and a three stage distance pipeline, then
//  runs a mark pass when it matches; a drain makes one pass over the
//  store. All passes share the single RAM read port.
//  rst is synchronous and clears the point count, so no clearing pass runs.
//  a full output register stalls the scan of a drain and the end of a query.
// ----------------------------------------------------------------------------
module nearest_point_match_threshold_unit (
  input  logic           clk,
  input  logic           rst,
  npm_in_if.sink         in_ch,
  npm_out_if.source      out_ch,
  input  logic           cfg_we,
  input  npm_pkg::dist_t cfg_wdata
);

  import npm_pkg::*;

  state_t   state, state_next;
  cnt_t     count, count_next;
  cnt_t     iss, iss_next;
  dist_t    thresh;
  coord_t   qx, qy;

  logic     re, we;
  idx_t     waddr;
  entry_t   wdata, rd;

  logic     a_valid, a_valid_next;
  idx_t     a_idx, a_idx_next;

  logic signed [COORD_W:0] a_dx, a_dy;
  logic [COORD_W-1:0]      a_adx, a_ady;

  logic               b_valid;
  idx_t               b_idx;
  logic [COORD_W-1:0] b_adx, b_ady;
  coord_t             b_x, b_y;

  logic            c_valid;
  idx_t            c_idx;
  logic [SQ_W-1:0] c_sqx, c_sqy;
  coord_t          c_x, c_y;
  dist_t           c_d;

  logic   found;
  idx_t   best_idx;
  dist_t  best_d;
  coord_t best_x, best_y;
  logic   hit;

  logic     pend_valid, pend_valid_next;
  idx_t     pend_idx;
  coord_t   pend_x, pend_y;
  logic     pend_load;
  res_cnt_t dn, dn_next;
  logic     unm, need_out, can_proc;

  logic     out_valid, out_free, out_load;
  kind_t    out_kind, out_kind_next;
  logic     out_matched, out_matched_next;
  ref_idx_t out_index, out_index_next;
  coord_t   out_px, out_px_next;
  coord_t   out_py, out_py_next;
  dist_t    out_dist, out_dist_next;
  logic     out_last, out_last_next;

  logic accept;

  npm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (iss[IDX_W-1:0]),
    .rdata (rd)
  );

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  assign out_ch.valid     = out_valid;
  assign out_ch.kind      = out_kind;
  assign out_ch.matched   = out_matched;
  assign out_ch.ref_index = out_index;
  assign out_ch.ref_px    = out_px;
  assign out_ch.ref_py    = out_py;
  assign out_ch.dist_sq   = out_dist;
  assign out_ch.last      = out_last;

  // distance pipeline front end, distance sum and threshold hit test
  always_comb begin
    a_dx  = {qx[COORD_W-1], qx} - {rd.x[COORD_W-1], rd.x};
    a_dy  = {qy[COORD_W-1], qy} - {rd.y[COORD_W-1], rd.y};
    a_adx = a_dx[COORD_W] ? COORD_W'(-a_dx) : COORD_W'(a_dx);
    a_ady = a_dy[COORD_W] ? COORD_W'(-a_dy) : COORD_W'(a_dy);
    c_d   = DIST_W'(c_sqx) + DIST_W'(c_sqy);
    hit   = found && (best_d < thresh);
  end

  // drain candidate handling
  always_comb begin
    unm      = a_valid && !rd.mark && (dn < RES_W'(RESULT_CAP));
    need_out = unm && pend_valid;
    can_proc = a_valid && (!need_out || out_free);
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    iss_next         = iss;
    a_valid_next     = 1'b0;
    a_idx_next       = a_idx;
    re               = 1'b0;
    we               = 1'b0;
    waddr            = a_idx;
    wdata            = rd;
    pend_valid_next  = pend_valid;
    pend_load        = 1'b0;
    dn_next          = dn;
    out_load         = 1'b0;
    out_kind_next    = KIND_QUERY;
    out_matched_next = 1'b0;
    out_index_next   = '0;
    out_px_next      = '0;
    out_py_next      = '0;
    out_dist_next    = '0;
    out_last_next    = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.operation)
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_LOAD: begin
              if (count < CNT_W'(STORE_DEPTH)) begin
                we         = 1'b1;
                waddr      = count[IDX_W-1:0];
                wdata      = '{mark: 1'b0, x: in_ch.point_x, y: in_ch.point_y};
                count_next = count + 1'b1;
              end
            end
            OP_QUERY: begin
              iss_next   = '0;
              state_next = (count == '0) ? ST_QOUT : ST_QSCAN;
            end
            OP_DRAIN: begin
              iss_next        = '0;
              dn_next         = '0;
              pend_valid_next = 1'b0;
              state_next      = (count == '0) ? ST_IDLE : ST_DRAIN;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_QSCAN: begin
        if (iss < count) begin
          re           = 1'b1;
          iss_next     = iss + 1'b1;
          a_valid_next = 1'b1;
          a_idx_next   = iss[IDX_W-1:0];
        end else if (!a_valid && !b_valid && !c_valid) begin
          state_next = ST_QOUT;
        end
      end

      ST_QOUT: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_kind_next    = KIND_QUERY;
          out_matched_next = hit;
          out_index_next   = found ? REF_IDX_W'(best_idx) : '0;
          out_px_next      = found ? best_x : '0;
          out_py_next      = found ? best_y : '0;
          out_dist_next    = found ? best_d : '0;
          out_last_next    = 1'b1;
          iss_next         = '0;
          state_next       = hit ? ST_MARK : ST_IDLE;
        end
      end

      ST_MARK: begin
        if (iss < count) begin
          re           = 1'b1;
          iss_next     = iss + 1'b1;
          a_valid_next = 1'b1;
          a_idx_next   = iss[IDX_W-1:0];
        end
        if (a_valid && rd.x == best_x && rd.y == best_y) begin
          we    = 1'b1;
          waddr = a_idx;
          wdata = '{mark: 1'b1, x: rd.x, y: rd.y};
        end
        if (iss >= count && !a_valid) begin
          state_next = ST_IDLE;
        end
      end

      ST_DRAIN: begin
        if (need_out && out_free) begin
          out_load       = 1'b1;
          out_kind_next  = KIND_DRAIN;
          out_index_next = REF_IDX_W'(pend_idx);
          out_px_next    = pend_x;
          out_py_next    = pend_y;
        end
        if (can_proc && unm) begin
          pend_valid_next = 1'b1;
          pend_load       = 1'b1;
          dn_next         = dn + 1'b1;
        end
        if ((!a_valid || can_proc) && iss < count) begin
          re           = 1'b1;
          iss_next     = iss + 1'b1;
          a_valid_next = 1'b1;
          a_idx_next   = iss[IDX_W-1:0];
        end else begin
          a_valid_next = a_valid && !can_proc;
        end
        if (iss >= count && !a_valid) begin
          if (!pend_valid) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            out_load        = 1'b1;
            out_kind_next   = KIND_DRAIN;
            out_index_next  = REF_IDX_W'(pend_idx);
            out_px_next     = pend_x;
            out_py_next     = pend_y;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
            state_next      = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      iss        <= '0;
      thresh     <= '0;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      dn         <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      iss        <= iss_next;
      a_valid    <= a_valid_next;
      b_valid    <= a_valid && (state == ST_QSCAN);
      c_valid    <= b_valid;
      pend_valid <= pend_valid_next;
      dn         <= dn_next;
      out_valid  <= out_load || (out_valid && !out_ch.ready);
      if (cfg_we) begin
        thresh <= cfg_wdata;
      end
      if (accept && in_ch.operation == OP_QUERY) begin
        found <= 1'b0;
      end else if (c_valid && (!found || c_d < best_d)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_idx <= a_idx_next;
    if (accept) begin
      qx <= in_ch.point_x;
      qy <= in_ch.point_y;
    end
    b_idx <= a_idx;
    b_adx <= a_adx;
    b_ady <= a_ady;
    b_x   <= rd.x;
    b_y   <= rd.y;
    c_idx <= b_idx;
    c_sqx <= SQ_W'(b_adx) * SQ_W'(b_adx);
    c_sqy <= SQ_W'(b_ady) * SQ_W'(b_ady);
    c_x   <= b_x;
    c_y   <= b_y;
    if (c_valid && (!found || c_d < best_d)) begin
      best_idx <= c_idx;
      best_d   <= c_d;
      best_x   <= c_x;
      best_y   <= c_y;
    end
    if (pend_load) begin
      pend_idx <= a_idx;
      pend_x   <= rd.x;
      pend_y   <= rd.y;
    end
    if (out_load) begin
      out_kind    <= out_kind_next;
      out_matched <= out_matched_next;
      out_index   <= out_index_next;
      out_px      <= out_px_next;
      out_py      <= out_py_next;
      out_dist    <= out_dist_next;
      out_last    <= out_last_next;
    end
  end

endmodule
